/* rtl/rbd_pkg.sv */
// rbd_pkg: shared types and constants for the rgb box downscaler
// no dependencies
package rbd_pkg;

  localparam int DATA_W         = 8;
  localparam int PIX_W          = 3 * DATA_W;
  localparam int SF_W           = 5;
  localparam int DIM_W          = 12;
  localparam int CFG_IDX_W      = 2;
  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_FACTOR = 16;

  localparam logic [CFG_IDX_W-1:0] REG_SCALE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

  localparam logic [SF_W-1:0]  RST_SCALE  = 5'd2;
  localparam logic [DIM_W-1:0] RST_WIDTH  = 12'd640;
  localparam logic [DIM_W-1:0] RST_HEIGHT = 12'd480;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WR,
    S_DIV,
    S_OUT
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

/* rtl/rbd_ram.sv */
// rbd_ram: generic single-write single-read ram with registered read data
// no dependencies
module rbd_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic                 re,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/rbd_div.sv */
// rbd_div: three-channel restoring divider, one quotient bit per cycle
// depends on rbd_pkg
module rbd_div #(
  parameter int CW = 16,
  parameter int NW = 10
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic [2:0][CW:0]                     dividend,
  input  logic [NW-1:0]                        divisor,
  output logic [2:0][rbd_pkg::DATA_W-1:0]      quot,
  output rbd_pkg::div_stat_t                   stat
);
  import rbd_pkg::*;

  localparam int XW = CW + NW + DATA_W + 1;
  localparam int SHW = $clog2(DATA_W);

  logic [2:0][CW:0]        rem_r;
  logic [2:0][DATA_W-1:0]  q_r;
  logic [NW-1:0]           d_r;
  logic [SHW-1:0]          sh_r;
  logic                    busy_r;
  logic                    done_r;
  logic [XW-1:0]           ds;

  assign ds = XW'(d_r) << sh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      sh_r   <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        sh_r   <= SHW'(DATA_W - 1);
        rem_r  <= dividend;
        d_r    <= divisor;
        q_r    <= '0;
      end else if (busy_r) begin
        for (int c = 0; c < 3; c++) begin
          if (XW'(rem_r[c]) >= ds) begin
            rem_r[c]     <= (CW+1)'(XW'(rem_r[c]) - ds);
            q_r[c][sh_r] <= 1'b1;
          end
        end
        if (sh_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          sh_r <= sh_r - SHW'(1);
        end
      end
    end
  end

  assign quot      = q_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

/* rtl/rgb_box_downscaler_top.sv */
// rgb_box_downscaler_top: box-filter image downscaler, column band sums in ram
// depends on rbd_pkg, rbd_ram, rbd_div
//
// Pixels enter in raster order, one transaction each. A pixel that does not close a
// block row leaves the input ready; one that closes a block's row holds the input
// for the read-modify-write of its column sum in the band ram; one that completes a
// block also holds it through the 8-step restoring divider and any wait for the
// output register to drain. The output register lets the next pixel enter while a
// result waits. No clearing pass: column sums are overwritten on the first row of
// each band. A write to the scale, width or height register restarts the frame.
module rgb_box_downscaler_top #(
  parameter int MAX_WIDTH  = rbd_pkg::DEF_MAX_WIDTH,
  parameter int MAX_FACTOR = rbd_pkg::DEF_MAX_FACTOR
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [rbd_pkg::PIX_W-1:0]     in_tdata,   // red, green, blue
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [rbd_pkg::PIX_W-1:0]     out_tdata,  // avg_red, avg_green, avg_blue
  output logic                          out_tlast,  // frame_end
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rbd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rbd_pkg::DIM_W-1:0]     cfg_data
);
  import rbd_pkg::*;

  localparam int FW = $clog2(MAX_FACTOR + 1);
  localparam int MW = $clog2(MAX_FACTOR);
  localparam int PW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int NW = 2 * FW;
  localparam int CW = $clog2(MAX_FACTOR * MAX_FACTOR * 255 + 1);
  localparam int SW = 3 * CW;

  logic [SF_W-1:0]  sf_r;
  logic [DIM_W-1:0] iw_r, ih_r;
  logic [PW-1:0]    col_r, bst_r, bx_r, row_r, rowst_r, waddr_r;
  logic [MW-1:0]    cm_r, rm_r;
  logic [2:0][CW-1:0] psum_r;
  logic             first_row_r, last_row_r, fend_r;
  state_t           state_r, state_nxt;
  logic             out_valid_r, out_last_r;
  logic [PIX_W-1:0] out_data_r;

  logic [FW-1:0]    f;
  logic [WW-1:0]    w, h;
  logic             accept, col_use, row_use, first_col, last_col, first_row, last_row;
  logic             last_cblk, last_rblk, load_out, div_start;
  logic [2:0][CW-1:0] pix, slot;
  logic [SW-1:0]    rdata;
  logic [FW-1:0]    bw, bh;
  logic [NW-1:0]    count;
  logic [2:0][CW:0] dvd;
  logic [2:0][DATA_W-1:0] quot;
  div_stat_t        dstat;

  always_comb begin
    if (sf_r == '0) f = FW'(1);
    else if (int'(sf_r) > MAX_FACTOR) f = FW'(MAX_FACTOR);
    else f = FW'(sf_r);
    if (iw_r == '0) w = WW'(1);
    else if (int'(iw_r) > MAX_WIDTH) w = WW'(MAX_WIDTH);
    else w = WW'(iw_r);
    if (ih_r == '0) h = WW'(1);
    else if (int'(ih_r) > MAX_WIDTH) h = WW'(MAX_WIDTH);
    else h = WW'(ih_r);
  end

  assign col_use   = (WW'(f) > w) || ((WW+1)'(bst_r) + (WW+1)'(f) <= (WW+1)'(w));
  assign row_use   = (WW'(f) > h) || ((WW+1)'(rowst_r) + (WW+1)'(f) <= (WW+1)'(h));
  assign first_col = (cm_r == '0);
  assign first_row = (rm_r == '0);
  assign last_col  = (FW'(cm_r) == f - FW'(1)) || (WW'(col_r) == w - WW'(1));
  assign last_row  = (FW'(rm_r) == f - FW'(1)) || (WW'(row_r) == h - WW'(1));
  assign last_cblk = (WW'(f) > w) ||
                     ((WW+2)'(bst_r) + ((WW+2)'(f) << 1) > (WW+2)'(w));
  assign last_rblk = (WW'(f) > h) ||
                     ((WW+2)'(rowst_r) + ((WW+2)'(f) << 1) > (WW+2)'(h));

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  for (genvar c = 0; c < 3; c++) begin : g_ch
    assign pix[c]  = CW'(in_tdata[c*DATA_W +: DATA_W]);
    assign slot[c] = first_row_r ? psum_r[c] : rdata[c*CW +: CW] + psum_r[c];
    assign dvd[c]  = (CW+1)'(slot[c]) + (CW+1)'(count >> 1);
  end

  assign bw    = (WW'(f) < w) ? f : FW'(w);
  assign bh    = (WW'(f) < h) ? f : FW'(h);
  assign count = NW'(bw) * NW'(bh);

  rbd_ram #(.W(SW), .D(MAX_WIDTH)) u_ram (
    .clk   (clk),
    .we    (state_r == S_WR),
    .waddr (waddr_r),
    .wdata (slot),
    .re    (accept),
    .raddr (bx_r),
    .rdata (rdata)
  );

  assign div_start = (state_r == S_WR) && last_row_r;

  rbd_div #(.CW(CW), .NW(NW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dvd),
    .divisor  (count),
    .quot     (quot),
    .stat     (dstat)
  );

  assign load_out = (state_r == S_OUT) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (accept && col_use && row_use && last_col) state_nxt = S_WR;
      S_WR:   state_nxt = last_row_r ? S_DIV : S_IDLE;
      S_DIV:  if (dstat.done) state_nxt = S_OUT;
      S_OUT:  if (load_out) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sf_r <= RST_SCALE;
      iw_r <= RST_WIDTH;
      ih_r <= RST_HEIGHT;
      col_r <= '0; cm_r <= '0; bst_r <= '0; bx_r <= '0;
      row_r <= '0; rm_r <= '0; rowst_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid_r <= 1'b1;
        out_data_r  <= quot;
        out_last_r  <= fend_r;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && (cfg_index == REG_SCALE || cfg_index == REG_WIDTH ||
                        cfg_index == REG_HEIGHT)) begin
        case (cfg_index)
          REG_SCALE:  sf_r <= cfg_data[SF_W-1:0];
          REG_WIDTH:  iw_r <= cfg_data;
          REG_HEIGHT: ih_r <= cfg_data;
          default:    sf_r <= sf_r;
        endcase
        col_r <= '0; cm_r <= '0; bst_r <= '0; bx_r <= '0;
        row_r <= '0; rm_r <= '0; rowst_r <= '0;
      end else if (accept) begin
        if (col_use && row_use) begin
          for (int c = 0; c < 3; c++) begin
            psum_r[c] <= first_col ? pix[c] : psum_r[c] + pix[c];
          end
          waddr_r     <= bx_r;
          first_row_r <= first_row;
          last_row_r  <= last_row;
          fend_r      <= last_cblk && last_rblk;
        end
        if (WW'(col_r) == w - WW'(1)) begin
          col_r <= '0; cm_r <= '0; bst_r <= '0; bx_r <= '0;
          if (WW'(row_r) == h - WW'(1)) begin
            row_r <= '0; rm_r <= '0; rowst_r <= '0;
          end else begin
            row_r <= row_r + PW'(1);
            if (FW'(rm_r) == f - FW'(1)) begin
              rm_r    <= '0;
              rowst_r <= rowst_r + PW'(f);
            end else begin
              rm_r <= rm_r + MW'(1);
            end
          end
        end else begin
          col_r <= col_r + PW'(1);
          if (FW'(cm_r) == f - FW'(1)) begin
            cm_r  <= '0;
            bst_r <= bst_r + PW'(f);
            bx_r  <= bx_r + PW'(1);
          end else begin
            cm_r <= cm_r + MW'(1);
          end
        end
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

/* rtl/rbd_chk.sv */
// rbd_chk: port-level checks for the rgb box downscaler, bound to the top level
// depends on rbd_pkg, rgb_box_downscaler_top
module rbd_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tvalid,
  input logic                          in_tready,
  input logic [rbd_pkg::PIX_W-1:0]     in_tdata,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [rbd_pkg::PIX_W-1:0]     out_tdata,
  input logic                          out_tlast,
  input logic                          cfg_valid,
  input logic                          cfg_ready,
  input logic [rbd_pkg::CFG_IDX_W-1:0] cfg_index,
  input logic [rbd_pkg::DIM_W-1:0]     cfg_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_new_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result appeared while input side idle");

  a_cfg_open: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("config channel stalled");

endmodule

bind rgb_box_downscaler_top rbd_chk u_chk (.*);

/* tb/rgb_box_downscaler_checker.sv */
// rgb_box_downscaler_checker: watches the pixel, result and register channels of the
// downscaler, predicts each block mean and compares it; depends on rbd_pkg
module rgb_box_downscaler_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  input  logic                          in_tready,
  input  logic [rbd_pkg::PIX_W-1:0]     in_tdata,
  input  logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic [rbd_pkg::PIX_W-1:0]     out_tdata,
  input  logic                          out_tlast,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [rbd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rbd_pkg::DIM_W-1:0]     cfg_data,
  output int                            errors,
  output int                            pending,
  output int                            results
);
  import rbd_pkg::*;

  localparam int MAXW = DEF_MAX_WIDTH;
  localparam int MAXF = DEF_MAX_FACTOR;
  localparam int BXW  = $clog2(MAXW);

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic       last;
  } box_mean_t;

  logic [SF_W-1:0]  sf_reg;
  logic [DIM_W-1:0] width_reg;
  logic [DIM_W-1:0] height_reg;
  logic [31:0]      col_pos;
  logic [31:0]      row_pos;
  logic [31:0]      run_r, run_g, run_b;
  logic [31:0]      band_r [MAXW];
  logic [31:0]      band_g [MAXW];
  logic [31:0]      band_b [MAXW];
  box_mean_t        box_means_q [$];

  initial begin
    errors = 0;
    pending = 0;
    results = 0;
  end

  function automatic logic [31:0] clamp_dim(logic [31:0] v);
    if (v == 0) return 1;
    if (v > MAXW) return MAXW;
    return v;
  endfunction

  function automatic logic [7:0] rounded_mean(logic [31:0] sum, logic [31:0] cnt);
    logic [31:0] q;
    q = (sum + cnt / 2) / cnt;
    return q[7:0];
  endfunction

  task automatic report_mismatch(string what, logic [7:0] want, logic [7:0] got);
    $display("mismatch %s: expected %0d got %0d", what, want, got);
    errors++;
  endtask

  task automatic accumulate_pixel(logic [PIX_W-1:0] px);
    logic [31:0] f, w, h, rw, rh, uc, uh, col, row, bx, by, cnt;
    logic        first_col, last_col, first_row, last_row;
    logic [BXW-1:0] bi;
    box_mean_t   m;
    f = sf_reg;
    w = clamp_dim(width_reg);
    h = clamp_dim(height_reg);
    if (f == 0) f = 1;
    if (f > MAXF) f = MAXF;
    rw = w / f; if (rw == 0) rw = 1;
    rh = h / f; if (rh == 0) rh = 1;
    uc = rw * f; if (uc > w) uc = w;
    uh = rh * f; if (uh > h) uh = h;
    col = col_pos;
    row = row_pos;
    if (col < uc && row < uh) begin
      bx = col / f;
      by = row / f;
      bi = bx[BXW-1:0];
      first_col = (col % f) == 0;
      last_col = ((col % f) == f - 1) || (col == w - 1);
      first_row = (row % f) == 0;
      last_row = ((row % f) == f - 1) || (row == h - 1);
      if (first_col) begin
        run_r = px[7:0];
        run_g = px[15:8];
        run_b = px[23:16];
      end else begin
        run_r += px[7:0];
        run_g += px[15:8];
        run_b += px[23:16];
      end
      if (last_col) begin
        if (first_row) begin
          band_r[bi] = run_r;
          band_g[bi] = run_g;
          band_b[bi] = run_b;
        end else begin
          band_r[bi] += run_r;
          band_g[bi] += run_g;
          band_b[bi] += run_b;
        end
        if (last_row) begin
          cnt = (f < w ? f : w) * (f < h ? f : h);
          m.r = rounded_mean(band_r[bi], cnt);
          m.g = rounded_mean(band_g[bi], cnt);
          m.b = rounded_mean(band_b[bi], cnt);
          m.last = (bx == rw - 1) && (by == rh - 1);
          box_means_q.push_back(m);
        end
      end
    end
    if (col >= w - 1) begin
      col_pos = 0;
      row_pos = (row >= h - 1) ? 0 : row + 1;
    end else begin
      col_pos = col + 1;
    end
  endtask

  always @(posedge clk) begin
    box_mean_t m;
    if (!rst_n) begin
      sf_reg = RST_SCALE;
      width_reg = RST_WIDTH;
      height_reg = RST_HEIGHT;
      col_pos = 0;
      row_pos = 0;
      run_r = 0; run_g = 0; run_b = 0;
      box_means_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SCALE: sf_reg = cfg_data[SF_W-1:0];
          REG_WIDTH: width_reg = cfg_data;
          REG_HEIGHT: height_reg = cfg_data;
          default: ;
        endcase
        if (cfg_index == REG_SCALE || cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT) begin
          col_pos = 0;
          row_pos = 0;
        end
      end
      if (in_tvalid && in_tready) accumulate_pixel(in_tdata);
      if (out_tvalid && out_tready) begin
        results++;
        if (box_means_q.size() == 0) begin
          $display("unexpected result transaction %h last %b", out_tdata, out_tlast);
          errors++;
        end else begin
          m = box_means_q.pop_front();
          if (out_tdata[7:0] !== m.r) report_mismatch("avg_red", m.r, out_tdata[7:0]);
          if (out_tdata[15:8] !== m.g) report_mismatch("avg_green", m.g, out_tdata[15:8]);
          if (out_tdata[23:16] !== m.b) report_mismatch("avg_blue", m.b, out_tdata[23:16]);
          if (out_tlast !== m.last) report_mismatch("frame_end", m.last, out_tlast);
        end
      end
    end
    pending = box_means_q.size();
  end
endmodule

/* tb/rgb_box_downscaler_top_test.sv */
// rgb_box_downscaler_top_test: drives pixel frames and register settings into
// the dut with random stalls; uses rbd_pkg, rgb_box_downscaler_{top,checker}
module rgb_box_downscaler_top_test;
  import rbd_pkg::*;

  localparam int IDLE_LIMIT = 5000;
  localparam int ITEM_GOAL  = 1650;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic                 clk = 0;
  logic                 rst_n = 0;
  logic                 in_tvalid = 0;
  logic                 in_tready;
  logic [PIX_W-1:0]     in_tdata = '0;
  logic                 out_tvalid;
  logic                 out_tready = 0;
  logic [PIX_W-1:0]     out_tdata;
  logic                 out_tlast;
  logic                 cfg_valid = 0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DIM_W-1:0]     cfg_data = '0;

  int errors, pending, results;
  int pixels_sent = 0;
  int frames_run = 0;
  bit calm = 0;
  bit long_hold = 0;

  always #1 clk = ~clk;

  rgb_box_downscaler_top dut (.*);

  rgb_box_downscaler_checker chk (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .out_tvalid, .out_tready,
    .out_tdata, .out_tlast, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .errors, .pending, .results
  );

  function automatic int clamp_dim(int v);
    if (v == 0) return 1;
    if (v > DEF_MAX_WIDTH) return DEF_MAX_WIDTH;
    return v;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 0;
  endtask

  task automatic send_pixel(logic [PIX_W-1:0] px);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= px;
    do @(negedge clk); while (!in_tready);
    @(posedge clk);
    pixels_sent++;
  endtask

  function automatic logic [7:0] rand_chan();
    case ($urandom_range(0, 5))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic settle();
    in_tvalid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic run_frames(int f, int w, int h, int extra);
    int n;
    write_reg(REG_SCALE, DIM_W'(f));
    write_reg(REG_WIDTH, DIM_W'(w));
    write_reg(REG_HEIGHT, DIM_W'(h));
    n = clamp_dim(w) * clamp_dim(h) * $urandom_range(1, 2) + extra;
    repeat (n) send_pixel({rand_chan(), rand_chan(), rand_chan()});
    frames_run++;
    settle();
  endtask

  // receiver with random stalls and one long hold-off
  initial begin
    int gap;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (long_hold) begin
        long_hold = 0;
        out_tready <= 0;
        repeat (400) @(posedge clk);
      end else begin
        gap = calm ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
          out_tready <= 0;
          repeat (gap) @(posedge clk);
        end
      end
      out_tready <= 1;
      do @(negedge clk); while (!out_tvalid);
      @(posedge clk);
    end
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        idle = 0;
      else
        idle++;
    end
    $display("timeout after %0d idle cycles", IDLE_LIMIT);
    $display("rgb_box_downscaler_top_test: done, errors");
    $finish;
  end

  initial begin
    int f, w, h;
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // extremes: all-max block then all-zero block, with a frame wrap
    write_reg(REG_SCALE, 12'd2);
    write_reg(REG_WIDTH, 12'd2);
    write_reg(REG_HEIGHT, 12'd2);
    repeat (4) send_pixel({8'd255, 8'd255, 8'd255});
    repeat (4) send_pixel({8'd0, 8'd0, 8'd0});
    settle();
    // zero factor acts as one, single row image
    write_reg(REG_SCALE, 12'd0);
    write_reg(REG_WIDTH, 12'd3);
    write_reg(REG_HEIGHT, 12'd1);
    send_pixel(24'h00ff80);
    send_pixel(24'hff0001);
    send_pixel(24'h7f7f7f);
    settle();
    // oversized factor saturates; block shrinks to the image
    write_reg(REG_UNUSED, 12'hfff);
    write_reg(REG_SCALE, 12'd31);
    write_reg(REG_WIDTH, 12'd5);
    write_reg(REG_HEIGHT, 12'd2);
    repeat (10) send_pixel({rand_chan(), rand_chan(), rand_chan()});
    settle();

    // saturated width, one row, largest factor, start of the row only
    calm = 1;
    write_reg(REG_SCALE, 12'd16);
    write_reg(REG_WIDTH, 12'hfff);
    write_reg(REG_HEIGHT, 12'd0);
    repeat (512) send_pixel({rand_chan(), rand_chan(), rand_chan()});
    frames_run++;
    settle();
    calm = 0;

    while (pixels_sent < ITEM_GOAL) begin
      f = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 5);
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095) % 64 : $urandom_range(1, 20);
      h = $urandom_range(0, 16);
      if (frames_run == 2) long_hold = 1;
      calm = ($urandom_range(0, 5) == 0);
      run_frames(f, w, h, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 0);
    end
    calm = 0;
    settle();
    repeat (30) @(posedge clk);
    $display("covered %0d pixels in %0d settings, %0d block means checked",
             pixels_sent, frames_run, results);
    if (errors == 0)
      $display("rgb_box_downscaler_top_test: done, clean");
    else
      $display("rgb_box_downscaler_top_test: done, errors");
    $finish;
  end
endmodule
